FILE: design/urc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc_pkg
// Shared widths, register codes, reset values and division constants for the
// ultrasonic ranging controller.
// ----------------------------------------------------------------------------
package urc_pkg;

  // register file
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_TIME_W = 20;
  localparam int LIMIT_W    = 15;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_TRIG_ON_TIME = 2'd0;
  localparam reg_idx_t REG_TRIG_PERIOD  = 2'd1;
  localparam reg_idx_t REG_RANGE_LIMIT  = 2'd2;

  localparam logic [CFG_TIME_W-1:0] TRIG_ON_TIME_RST = 20'd15;
  localparam logic [CFG_TIME_W-1:0] TRIG_PERIOD_RST  = 20'd500000;
  localparam logic [LIMIT_W-1:0]    RANGE_LIMIT_RST  = 15'd100;

  // result widths
  localparam int DIST_W   = 15;
  localparam int PERIOD_W = 18;
  localparam int ON_W     = 17;

  localparam logic [DIST_W-1:0] DIST_MAX = 15'd18078;

  // width / 58 by reciprocal; exact for widths below 2^21
  localparam int                 WIDE_W      = 32;
  localparam int                 QUOT_IN_W   = 21;
  localparam int                 RECIP_W     = 22;
  localparam int                 RECIP_SHIFT = 27;
  localparam logic [RECIP_W-1:0] RECIP       = 22'd2314099;
  // smallest width whose distance reaches past the clamp, 58 * 18079
  localparam logic [WIDE_W-1:0]  DIV_LIMIT   = 32'd1048582;

endpackage

FILE: design/urc_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urc channel interfaces
// Valid/ready channels for echo samples in and ranging results out.
// ----------------------------------------------------------------------------
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface urc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger_level;
  logic                       measure_done;
  logic [urc_pkg::DIST_W-1:0]   distance_cm;
  logic                       in_range;
  logic [urc_pkg::PERIOD_W-1:0] blink_period;
  logic [urc_pkg::ON_W-1:0]     blink_on_time;

  modport source (output valid, output trigger_level, output measure_done,
                  output distance_cm, output in_range, output blink_period,
                  output blink_on_time, input ready);
  modport sink   (input valid, input trigger_level, input measure_done,
                  input distance_cm, input in_range, input blink_period,
                  input blink_on_time, output ready);
endinterface

FILE: design/ultrasonic_ranging_controller.sv
`timescale 1ns / 1ps
// a tick passes three registers in order: stage 1, stage 2 and the output register
// throughput: one tick per cycle while no stage holds, set by the trigger/echo update
// a stage holds only while the next stage is full and not taken; input ready drops
// once all three stages are full and the output is not taken
// rst_n is synchronous: registers return to reset values, except the stage data and
// out_trig/out_done registers; trigger restarts on next tick
// ----------------------------------------------------------------------------
// ultrasonic_ranging_controller
// Periodic trigger pulse generation and echo width to distance conversion,
// one microsecond tick per transaction, with an APB-style register port.
// ----------------------------------------------------------------------------
module ultrasonic_ranging_controller #(
  parameter int TIMER_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  urc_in_if.sink                         in_ch,
  urc_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [urc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [urc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [urc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import urc_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  // configuration registers
  logic [CFG_TIME_W-1:0] trig_on_time_r;
  logic [CFG_TIME_W-1:0] trig_period_r;
  logic [LIMIT_W-1:0]    range_limit_r;
  reg_idx_t              reg_idx;
  logic                  cfg_wr;

  // tick state
  logic                  started_r;
  logic                  trig_on_r,    trig_on_nxt;
  logic [TIMER_BITS-1:0] elapsed_r,    elapsed_nxt;
  logic                  echo_prev_r;
  logic [TIMER_BITS-1:0] echo_width_r, echo_width_nxt;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [WIDE_W-1:0]     elapsed_ext;
  logic                  echo_rise, echo_fall;

  // pipeline stages
  logic                  s1_valid_r, s1_trig_r, s1_done_r;
  logic [TIMER_BITS-1:0] s1_width_r;
  logic                  s2_valid_r, s2_trig_r, s2_done_r, s2_sat_r;
  logic [DIST_W-1:0]     s2_quot_r;
  logic                  out_valid_r, out_trig_r, out_done_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic                  out_flag_r;
  logic [PERIOD_W-1:0]   out_period_r;

  logic                  adv_out, adv_s2, in_take;
  logic [WIDE_W-1:0]     width_ext;
  logic [QUOT_IN_W+RECIP_W-1:0] quot_prod;
  logic [DIST_W-1:0]     dist_sel;
  logic [PERIOD_W-1:0]   dist_wide, period_calc;

  // ---------------- register port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_on_time_r <= TRIG_ON_TIME_RST;
      trig_period_r  <= TRIG_PERIOD_RST;
      range_limit_r  <= RANGE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRIG_ON_TIME: trig_on_time_r <= pwdata[CFG_TIME_W-1:0];
        REG_TRIG_PERIOD:  trig_period_r  <= pwdata[CFG_TIME_W-1:0];
        REG_RANGE_LIMIT:  range_limit_r  <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIG_ON_TIME: prdata = CFG_DATA_W'(trig_on_time_r);
      REG_TRIG_PERIOD:  prdata = CFG_DATA_W'(trig_period_r);
      REG_RANGE_LIMIT:  prdata = CFG_DATA_W'(range_limit_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign adv_out     = !out_valid_r || out_ch.ready;
  assign adv_s2      = !s2_valid_r || adv_out;
  assign in_ch.ready = !s1_valid_r || adv_s2;
  assign in_take     = in_ch.valid && in_ch.ready;

  // ---------------- trigger and echo state update ----------------
  assign echo_rise = in_ch.echo_level && !echo_prev_r;
  assign echo_fall = !in_ch.echo_level && echo_prev_r;

  always_comb begin
    logic trig_cur;
    trig_cur    = started_r ? trig_on_r : 1'b1;
    elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
    elapsed_nxt = started_r ? elapsed_inc : '0;
    elapsed_ext = WIDE_W'(elapsed_nxt);
    trig_on_nxt = trig_cur;
    priority if (trig_cur && elapsed_ext >= WIDE_W'(trig_on_time_r)) begin
      trig_on_nxt = 1'b0;
    end else if (elapsed_ext >= WIDE_W'(trig_period_r)) begin
      trig_on_nxt = 1'b1;
      elapsed_nxt = '0;
    end else begin
    end

    echo_width_nxt = echo_width_r;
    if (echo_prev_r && echo_width_r != TIMER_MAX) begin
      echo_width_nxt = echo_width_r + 1'b1;
    end
    if (echo_rise) begin
      echo_width_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      trig_on_r    <= 1'b0;
      elapsed_r    <= '0;
      echo_prev_r  <= 1'b0;
      echo_width_r <= '0;
    end else if (in_take) begin
      started_r    <= 1'b1;
      trig_on_r    <= trig_on_nxt;
      elapsed_r    <= elapsed_nxt;
      echo_prev_r  <= in_ch.echo_level;
      echo_width_r <= echo_width_nxt;
    end
  end

  // stage 1: per-tick trigger level and captured echo width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_trig_r  <= trig_on_nxt;
      s1_done_r  <= echo_fall;
      s1_width_r <= echo_width_nxt;
    end
  end

  // stage 2: width / 58 by reciprocal multiply, clamp detect in parallel
  assign width_ext = WIDE_W'(s1_width_r);
  assign quot_prod = width_ext[QUOT_IN_W-1:0] * RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv_s2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s2 && s1_valid_r) begin
      s2_trig_r <= s1_trig_r;
      s2_done_r <= s1_done_r;
      s2_sat_r  <= width_ext >= DIV_LIMIT;
      s2_quot_r <= quot_prod[RECIP_SHIFT +: DIST_W];
    end
  end

  // output stage: held distance, range flag and blink timing
  assign dist_sel    = s2_sat_r ? DIST_MAX : s2_quot_r;
  assign dist_wide   = PERIOD_W'(dist_sel);
  assign period_calc = (dist_wide << 3) + (dist_wide << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_dist_r   <= '0;
      out_flag_r   <= 1'b0;
      out_period_r <= '0;
    end else if (adv_out) begin
      out_valid_r <= s2_valid_r;
      if (s2_valid_r && s2_done_r) begin
        out_dist_r   <= dist_sel;
        out_flag_r   <= dist_sel <= range_limit_r;
        out_period_r <= period_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s2_valid_r) begin
      out_trig_r <= s2_trig_r;
      out_done_r <= s2_done_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_level = out_trig_r;
  assign out_ch.measure_done  = out_done_r;
  assign out_ch.distance_cm   = out_dist_r;
  assign out_ch.in_range      = out_flag_r;
  assign out_ch.blink_period  = out_period_r;
  assign out_ch.blink_on_time = out_period_r[PERIOD_W-1:1];

endmodule
